@@ rtl/lsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and codes for the LRU slot allocator
// Request and result formats and the action codes.
// ----------------------------------------------------------------------------
package lsa_pkg;

  // Action codes; code 3 is unused and changes nothing
  localparam logic [1:0] ACT_TOUCH   = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Widths of the stream payloads
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // One request item
  typedef struct packed {
    logic [2:0] slot_index;
    logic [1:0] action;
  } req_t;

  // One result item
  typedef struct packed {
    logic       evicted;
    logic [2:0] granted_slot;
  } rsp_t;

endpackage

@@ rtl/lsa_in_stage.sv @@
// ----------------------------------------------------------------------------
// lsa_in_stage: input register
// Captures one request item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lsa_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lsa_pkg::req_t in_req,
  output logic          req_valid,
  output lsa_pkg::req_t req,
  input  logic          take
);

  logic          valid_r;
  logic          valid_nxt;
  lsa_pkg::req_t req_r;

  // accept while empty or while the held item leaves this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

@@ rtl/lsa_core.sv @@
// ----------------------------------------------------------------------------
// lsa_core: slot state and single-pass update
// Holds used flags and age ranks; computes grant, eviction and new state.
// ----------------------------------------------------------------------------
module lsa_core #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lsa_pkg::req_t req,
  input  logic          take,
  output lsa_pkg::rsp_t rsp
);

  localparam int RW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [RW-1:0] OLDEST_RANK = RW'(SLOTS - 1);

  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] used_nxt;
  logic [RW-1:0]    rank_r   [SLOTS];
  logic [RW-1:0]    rank_nxt [SLOTS];

  logic          is_alloc;
  logic          idx_ok;
  logic [RW-1:0] idx_sel;
  logic          found;
  logic [RW-1:0] free_idx;
  logic [RW-1:0] old_idx;
  logic [RW-1:0] target;
  logic [RW-1:0] target_rank;
  logic          do_touch;

  assign is_alloc = (req.action == lsa_pkg::ACT_ALLOC);
  assign idx_ok   = (32'(req.slot_index) < SLOTS);
  assign idx_sel  = RW'(req.slot_index);
  assign found    = ~&used_r;

  // lowest free slot: priority encoder
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = RW'(i);
      end
    end
  end

  // ranks are a permutation, so the oldest slot holds the top rank
  always_comb begin
    old_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rank_r[i] == OLDEST_RANK) begin
        old_idx = RW'(i);
      end
    end
  end

  assign target      = is_alloc ? (found ? free_idx : old_idx) : idx_sel;
  assign target_rank = rank_r[target];
  assign do_touch    = is_alloc || ((req.action == lsa_pkg::ACT_TOUCH) && idx_ok);

  // rank update: younger slots age by one, the touched slot goes to zero
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (RW'(i) == target) begin
          rank_nxt[i] = '0;
        end else if (rank_r[i] < target_rank) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end
    end
  end

  // used flags
  always_comb begin
    used_nxt = used_r;
    if (is_alloc) begin
      used_nxt[target] = 1'b1;
    end else if ((req.action == lsa_pkg::ACT_RELEASE) && idx_ok) begin
      used_nxt[idx_sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rank_r[i] <= RW'(i);
      end
    end else if (take) begin
      used_r <= used_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // result: grant for allocate, echo otherwise
  assign rsp.granted_slot = is_alloc ? 3'(target) : req.slot_index;
  assign rsp.evicted      = is_alloc && !found;

endmodule

@@ rtl/lsa_out_stage.sv @@
// ----------------------------------------------------------------------------
// lsa_out_stage: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module lsa_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  lsa_pkg::rsp_t rsp,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output lsa_pkg::rsp_t out_rsp
);

  logic          valid_r;
  logic          valid_nxt;
  lsa_pkg::rsp_t rsp_r;

  // free when empty or when the held item leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

@@ rtl/lru_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// lru_slot_allocator: LRU slot allocator with age-rank counters
// Touch, allocate and release on a set of slots, one item per cycle while out_tready is high.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_*    | input     | tdata[1:0] action, tdata[4:2] slot_index
// out_*   | output    | tdata[2:0] granted_slot, tdata[3] evicted
//
// An item is held in the input register and then moves to the result register,
// which drives out_tvalid; one item per cycle is sustained while out_tready
// is high. The free search, top-rank match and rank update are combinational
// between the two registers.
// Reset frees all slots and sets each rank to its slot number.
// A stall on out_tready holds the result and backs up into in_tready.
// ----------------------------------------------------------------------------
module lru_slot_allocator #(
  parameter int SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lsa_pkg::IN_DATA_W-1:0]  in_tdata,   // [1:0] action, [4:2] slot_index
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lsa_pkg::OUT_DATA_W-1:0] out_tdata   // [2:0] granted_slot, [3] evicted
);

  lsa_pkg::req_t in_req;
  lsa_pkg::req_t req;
  lsa_pkg::rsp_t rsp;
  lsa_pkg::rsp_t out_rsp;
  logic          req_valid;
  logic          can_load;
  logic          take;

  // unpack input item
  assign in_req.action     = in_tdata[1:0];
  assign in_req.slot_index = in_tdata[4:2];

  // request moves on when the result register has room
  assign take = req_valid && can_load;

  lsa_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req       (req),
    .take      (take)
  );

  lsa_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .take  (take),
    .rsp   (rsp)
  );

  lsa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .rsp       (rsp),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rsp   (out_rsp)
  );

  // pack result item, zero fill to a byte
  assign out_tdata = {4'b0000, out_rsp.evicted, out_rsp.granted_slot};

endmodule
